// ===== design/shell_word_splitter_top_macros.svh =====
// ----------------------------------------------------------------------------
// shell word splitter assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SHELL_WORD_SPLITTER_TOP_MACROS_SVH
`define SHELL_WORD_SPLITTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define SWS_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sws check failed");

// consequent holds in the same cycle as the antecedent
`define SWS_CHECK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sws implication failed");

// consequent holds in the cycle after the antecedent
`define SWS_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sws next-cycle check failed");

`else

`define SWS_CHECK(lbl, cond)
`define SWS_CHECK_IMPL(lbl, ante, cons)
`define SWS_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// shared codes, result record and character helpers of the word splitter
// ----------------------------------------------------------------------------
package sws_pkg;

  // lexer state codes
  localparam logic [2:0] LX_BLANK = 3'd0;
  localparam logic [2:0] LX_WORD  = 3'd1;
  localparam logic [2:0] LX_SQ    = 3'd2;
  localparam logic [2:0] LX_DQ    = 3'd3;
  localparam logic [2:0] LX_BK0   = 3'd4;
  localparam logic [2:0] LX_BK1   = 3'd5;
  localparam logic [2:0] LX_BK2   = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LF     = 8'h0a;

  localparam logic [7:0] MAX_WORDS_RESET = 8'd64;

  // one result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] cnt;
    logic       ovf;
    logic       last;
  } res_t;

  // outcome of one byte in word, single or double quote state
  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] nstate;
    logic       sv_we;
    logic       sv_val;
  } qstep_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // single-letter escapes, anything else passes literally
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    priority if (c == CH_B) v = CH_BS;
    else if (c == CH_F) v = CH_FF;
    else if (c == CH_N) v = CH_LF;
    else if (c == CH_R) v = CH_CR;
    else if (c == CH_T) v = CH_TAB;
    else v = c;
    return v;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [7:0] idx, input logic [7:0] cnt,
                                  input logic ovf);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.idx  = idx;
    r.cnt  = cnt;
    r.ovf  = ovf;
    r.last = 1'b0;
    return r;
  endfunction

  // byte handling inside a word or a quote
  function automatic qstep_t quoted_step(input logic [2:0] st, input logic [7:0] c);
    qstep_t q;
    q.emit   = 1'b0;
    q.kind   = KIND_BYTE;
    q.data   = c;
    q.nstate = st;
    q.sv_we  = 1'b0;
    q.sv_val = 1'b0;
    unique case (st)
      LX_SQ: begin
        if (c == CH_SQUOTE) q.nstate = LX_WORD;
        else q.emit = 1'b1;
      end
      LX_DQ: begin
        priority if (c == CH_BSLASH) begin
          q.sv_we  = 1'b1;
          q.sv_val = 1'b1;
          q.nstate = LX_BK0;
        end else if (c == CH_DQUOTE) begin
          q.nstate = LX_WORD;
        end else begin
          q.emit = 1'b1;
        end
      end
      default: begin
        q.nstate = LX_WORD;
        priority if (is_space(c)) begin
          q.emit   = 1'b1;
          q.kind   = KIND_END;
          q.data   = CH_NUL;
          q.nstate = LX_BLANK;
        end else if (c == CH_SQUOTE) begin
          q.nstate = LX_SQ;
        end else if (c == CH_DQUOTE) begin
          q.nstate = LX_DQ;
        end else if (c == CH_BSLASH) begin
          q.sv_we  = 1'b1;
          q.nstate = LX_BK0;
        end else begin
          q.emit = 1'b1;
        end
      end
    endcase
    return q;
  endfunction

endpackage

// ===== design/sws_lexer.sv =====
// ----------------------------------------------------------------------------
// sws_lexer
// per-byte lexer state and the up to two results one byte produces
// ----------------------------------------------------------------------------
`include "shell_word_splitter_top_macros.svh"

module sws_lexer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          in_accept,
  input  logic [7:0]    in_byte,
  output logic [1:0]    res_n,
  output sws_pkg::res_t res0,
  output sws_pkg::res_t res1
);
  import sws_pkg::*;

  logic [2:0] state_r, state_nxt;
  logic       saved_r, saved_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [7:0] words_r, words_nxt;
  logic       stopped_r, stopped_nxt;
  logic       ovf_r, ovf_nxt;
  logic [7:0] max_words_r;

  logic [2:0] back;
  logic [2:0] qsel;
  logic [7:0] idx_cur;
  logic [7:0] acc_shift;
  qstep_t     qs;
  res_t       r0, r1;
  logic [1:0] n;

  assign back      = saved_r ? LX_DQ : LX_WORD;
  assign idx_cur   = words_r - 8'd1;
  assign acc_shift = {acc_r[4:0], in_byte[2:0]};

  // state that the quoted handling runs in for this byte
  always_comb begin
    if (state_r == LX_WORD || state_r == LX_SQ || state_r == LX_DQ) qsel = state_r;
    else if (state_r == LX_BK1 || state_r == LX_BK2) qsel = back;
    else qsel = LX_WORD;
  end

  assign qs = quoted_step(qsel, in_byte);

  // next state and results
  always_comb begin
    state_nxt   = state_r;
    saved_nxt   = saved_r;
    acc_nxt     = acc_r;
    words_nxt   = words_r;
    stopped_nxt = stopped_r;
    ovf_nxt     = ovf_r;
    r0 = mk_res(KIND_BYTE, CH_NUL, 8'd0, 8'd0, 1'b0);
    r1 = mk_res(KIND_BYTE, CH_NUL, 8'd0, 8'd0, 1'b0);
    n  = 2'd0;
    if (in_byte == CH_NUL) begin
      // line end: close open word, then summary, then clear the line
      if (state_r != LX_BLANK && state_r <= LX_BK2) begin
        r0 = mk_res(KIND_END, CH_NUL, idx_cur, 8'd0, 1'b0);
        r1 = mk_res(KIND_SUMMARY, CH_NUL, 8'd0, words_r, ovf_r);
        n  = 2'd2;
      end else begin
        r0 = mk_res(KIND_SUMMARY, CH_NUL, 8'd0, words_r, ovf_r);
        n  = 2'd1;
      end
      state_nxt   = LX_BLANK;
      saved_nxt   = 1'b0;
      acc_nxt     = 8'd0;
      words_nxt   = 8'd0;
      stopped_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end else if (!stopped_r) begin
      unique case (state_r)
        LX_WORD, LX_SQ, LX_DQ: begin
          state_nxt = qs.nstate;
          if (qs.sv_we) saved_nxt = qs.sv_val;
          if (qs.emit) begin
            r0 = mk_res(qs.kind, qs.data, idx_cur, 8'd0, 1'b0);
            n  = 2'd1;
          end
        end
        LX_BK0: begin
          if (is_oct(in_byte)) begin
            acc_nxt   = {5'd0, in_byte[2:0]};
            state_nxt = LX_BK1;
          end else begin
            state_nxt = back;
            r0 = mk_res(KIND_BYTE, esc_map(in_byte), idx_cur, 8'd0, 1'b0);
            n  = 2'd1;
          end
        end
        LX_BK1, LX_BK2: begin
          if (is_oct(in_byte)) begin
            if (state_r == LX_BK1) begin
              acc_nxt   = acc_shift;
              state_nxt = LX_BK2;
            end else begin
              state_nxt = back;
              r0 = mk_res(KIND_BYTE, acc_shift, idx_cur, 8'd0, 1'b0);
              n  = 2'd1;
            end
          end else begin
            // flush the escape, then handle the byte in the restored state
            r0 = mk_res(KIND_BYTE, acc_r, idx_cur, 8'd0, 1'b0);
            state_nxt = qs.nstate;
            if (qs.sv_we) saved_nxt = qs.sv_val;
            if (qs.emit) begin
              r1 = mk_res(qs.kind, qs.data, idx_cur, 8'd0, 1'b0);
              n  = 2'd2;
            end else begin
              n  = 2'd1;
            end
          end
        end
        default: begin
          // blank, also for the unused code
          state_nxt = LX_BLANK;
          priority if (is_space(in_byte)) begin
            state_nxt = LX_BLANK;
          end else if (in_byte == CH_HASH) begin
            stopped_nxt = 1'b1;
          end else if (words_r >= max_words_r) begin
            ovf_nxt     = 1'b1;
            stopped_nxt = 1'b1;
          end else begin
            words_nxt = words_r + 8'd1;
            state_nxt = qs.nstate;
            if (qs.sv_we) saved_nxt = qs.sv_val;
            if (qs.emit) begin
              r0 = mk_res(qs.kind, qs.data, words_r, 8'd0, 1'b0);
              n  = 2'd1;
            end
          end
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
  end

  assign res_n = n;
  assign res0  = r0;
  assign res1  = r1;

  // lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= LX_BLANK;
      saved_r   <= 1'b0;
      acc_r     <= 8'd0;
      words_r   <= 8'd0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (in_accept) begin
      state_r   <= state_nxt;
      saved_r   <= saved_nxt;
      acc_r     <= acc_nxt;
      words_r   <= words_nxt;
      stopped_r <= stopped_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // word limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_words_r <= MAX_WORDS_RESET;
    end else if (cfg_we) begin
      max_words_r <= cfg_wdata;
    end
  end

  // checks
  `SWS_CHECK_IMPL(a_last_on_final, res_n == 2'd2, !res0.last && res1.last)
  `SWS_CHECK_IMPL(a_summary_only_at_end, in_byte != CH_NUL,
                  res0.kind != KIND_SUMMARY && res1.kind != KIND_SUMMARY)
  `SWS_CHECK_NEXT(a_line_cleared, in_accept && in_byte == CH_NUL,
                  state_r == LX_BLANK && words_r == 8'd0 && !stopped_r && !ovf_r)

endmodule

// ===== design/sws_res_queue.sv =====
// ----------------------------------------------------------------------------
// sws_res_queue
// three-slot shifting result queue, slot zero drives the output
// ----------------------------------------------------------------------------
`include "shell_word_splitter_top_macros.svh"

module sws_res_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  sws_pkg::res_t push0,
  input  sws_pkg::res_t push1,
  input  logic          pop,
  output logic          room,
  output logic          head_valid,
  output sws_pkg::res_t head
);
  import sws_pkg::*;

  localparam int unsigned DEPTH = 3;

  res_t       q_r   [DEPTH];
  res_t       q_nxt [DEPTH];
  res_t       sh    [DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_ap;

  assign cnt_ap     = cnt_r - {1'b0, pop};
  assign cnt_nxt    = cnt_ap + push_n;
  assign room       = (cnt_r <= 2'd1);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[0];

  // shift out the taken result, then append new ones behind the rest
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) sh[i] = q_r[i + 1];
      else sh[i] = q_r[i];
      if (2'(i) < cnt_ap) q_nxt[i] = sh[i];
      else if (2'(i) == cnt_ap && push_n != 2'd0) q_nxt[i] = push0;
      else if (2'(i) == cnt_ap + 2'd1 && push_n == 2'd2) q_nxt[i] = push1;
      else q_nxt[i] = sh[i];
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // checks
  `SWS_CHECK(a_no_overfill, ({1'b0, cnt_ap} + {1'b0, push_n}) <= 3'd3)
  `SWS_CHECK_IMPL(a_push_needs_room, push_n != 2'd0, cnt_r <= 2'd1)

endmodule

// ===== design/shell_word_splitter_top.sv =====
// Output: a byte's results are registered in the result queue when it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and
//   out_tready stays high; a byte with two results (escape flush, line end of an
//   open word) needs two transfers on the single result port, and in_tready is low
//   while the three-slot result queue holds more than one result. Reset: synchronous
//   on rst_n low; lexer back to blank, counts cleared, max_words to 64, queue emptied.
// ----------------------------------------------------------------------------
// shell_word_splitter_top
// splits a zero-terminated byte line into sh-style quoted words
// ----------------------------------------------------------------------------
module shell_word_splitter_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // max_words
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] out_byte, [15:8] word_index,
                                   // [23:16] word_count, [24] overflow, rest zero
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast    // last result of its input byte
);
  import sws_pkg::*;

  logic       in_accept;
  logic [1:0] res_n;
  logic [1:0] push_n;
  res_t       res0, res1;
  res_t       head;
  logic       room;
  logic       head_valid;

  assign in_tready = room;
  assign in_accept = in_tvalid & room;
  assign push_n    = in_accept ? res_n : 2'd0;

  sws_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  sws_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push0      (res0),
    .push1      (res1),
    .pop        (head_valid & out_tready),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  // output packing
  assign out_tvalid = head_valid;
  assign out_tdata  = {7'd0, head.ovf, head.cnt, head.idx, head.data};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives zero-terminated byte lines into the shell word splitter and checks
// every result transfer against an in-bench model of the lexer, with random
// sender gaps, receiver stalls and changes of the word limit between lines
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = 8'd0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;  // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [7:0] out_byte, [15:8] word_index,
                                   // [23:16] word_count, [24] overflow
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        out_tlast;

  // lexer model state, reset values
  logic [2:0]  lex_st      = LX_BLANK;
  logic        dq_return   = 1'b0;
  logic [7:0]  oct_acc     = 8'd0;
  logic [7:0]  word_total  = 8'd0;
  logic        line_muted  = 1'b0;
  logic        ovf_seen    = 1'b0;
  logic [7:0]  word_limit  = MAX_WORDS_RESET;

  res_t        step_results[$];
  res_t        awaited_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatch_count = 0;
  int unsigned sent_items     = 0;
  int unsigned quiet_cycles   = 0;

  shell_word_splitter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // character classes
  function automatic logic white_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic octal_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] c);
    case (c)
      CH_B: return CH_BS;
      CH_F: return CH_FF;
      CH_N: return CH_LF;
      CH_R: return CH_CR;
      CH_T: return CH_TAB;
      default: return c;
    endcase
  endfunction

  // at most two results per byte
  task automatic add_result(input logic [1:0] kind, input logic [7:0] data,
                            input logic [7:0] cnt, input logic ovf);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.idx  = (kind == KIND_SUMMARY) ? 8'd0 : word_total - 8'd1;
    r.cnt  = cnt;
    r.ovf  = ovf;
    r.last = 1'b0;
    if (step_results.size() < 2) step_results.push_back(r);
  endtask

  // advance the lexer model by one byte and queue what it yields
  task automatic predict_byte(input logic [7:0] c);
    logic [2:0] ret;
    logic       again;
    logic       word_byte;
    step_results.delete();
    if (c == CH_NUL) begin
      // line end closes an open word, drops a pending octal escape
      if (lex_st != LX_BLANK) add_result(KIND_END, 8'd0, 8'd0, 1'b0);
      add_result(KIND_SUMMARY, 8'd0, word_total, ovf_seen);
      lex_st     = LX_BLANK;
      dq_return  = 1'b0;
      oct_acc    = 8'd0;
      word_total = 8'd0;
      line_muted = 1'b0;
      ovf_seen   = 1'b0;
    end else if (!line_muted) begin
      again = 1'b1;
      while (again) begin
        again     = 1'b0;
        word_byte = 1'b0;
        ret       = dq_return ? LX_DQ : LX_WORD;
        case (lex_st)
          LX_WORD: word_byte = 1'b1;
          LX_SQ: begin
            if (c == CH_SQUOTE) lex_st = LX_WORD;
            else add_result(KIND_BYTE, c, 8'd0, 1'b0);
          end
          LX_DQ: begin
            if (c == CH_BSLASH) begin
              dq_return = 1'b1;
              lex_st    = LX_BK0;
            end else if (c == CH_DQUOTE) begin
              lex_st = LX_WORD;
            end else begin
              add_result(KIND_BYTE, c, 8'd0, 1'b0);
            end
          end
          LX_BK0: begin
            if (octal_digit(c)) begin
              oct_acc = {5'd0, c[2:0]};
              lex_st  = LX_BK1;
            end else begin
              lex_st = ret;
              add_result(KIND_BYTE, escape_value(c), 8'd0, 1'b0);
            end
          end
          LX_BK1: begin
            if (octal_digit(c)) begin
              oct_acc = {oct_acc[4:0], c[2:0]};
              lex_st  = LX_BK2;
            end else begin
              // flush the digit, then handle the byte again
              add_result(KIND_BYTE, oct_acc, 8'd0, 1'b0);
              lex_st = ret;
              again  = 1'b1;
            end
          end
          LX_BK2: begin
            lex_st = ret;
            if (octal_digit(c)) begin
              add_result(KIND_BYTE, {oct_acc[4:0], c[2:0]}, 8'd0, 1'b0);
            end else begin
              add_result(KIND_BYTE, oct_acc, 8'd0, 1'b0);
              again = 1'b1;
            end
          end
          default: begin
            // blank: comment, word limit or a new word
            lex_st = LX_BLANK;
            if (!white_space(c)) begin
              if (c == CH_HASH) begin
                line_muted = 1'b1;
              end else if (word_total >= word_limit) begin
                ovf_seen   = 1'b1;
                line_muted = 1'b1;
              end else begin
                word_total = word_total + 8'd1;
                lex_st     = LX_WORD;
                word_byte  = 1'b1;
              end
            end
          end
        endcase
        // byte inside a bare word
        if (word_byte) begin
          if (white_space(c)) begin
            add_result(KIND_END, 8'd0, 8'd0, 1'b0);
            lex_st = LX_BLANK;
          end else if (c == CH_SQUOTE) begin
            lex_st = LX_SQ;
          end else if (c == CH_DQUOTE) begin
            lex_st = LX_DQ;
          end else if (c == CH_BSLASH) begin
            dq_return = 1'b0;
            lex_st    = LX_BK0;
          end else begin
            add_result(KIND_BYTE, c, 8'd0, 1'b0);
          end
        end
      end
    end
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) awaited_results.push_back(step_results[i]);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s, got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // input transfers feed the model, result transfers are checked in order
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sent_items++;
        predict_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transfer", out_tdata, 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser != want.kind)
            report_mismatch("kind", 32'(out_tuser), 32'(want.kind));
          if (out_tdata[7:0] != want.data)
            report_mismatch("out_byte", 32'(out_tdata[7:0]), 32'(want.data));
          if (out_tdata[15:8] != want.idx)
            report_mismatch("word_index", 32'(out_tdata[15:8]), 32'(want.idx));
          if (out_tdata[23:16] != want.cnt)
            report_mismatch("word_count", 32'(out_tdata[23:16]), 32'(want.cnt));
          if (out_tdata[24] != want.ovf)
            report_mismatch("overflow", 32'(out_tdata[24]), 32'(want.ovf));
          if (out_tdata[31:25] != 7'd0)
            report_mismatch("padding", 32'(out_tdata[31:25]), 32'd0);
          if (out_tlast != want.last)
            report_mismatch("tlast", 32'(out_tlast), 32'(want.last));
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one byte transfer, with random gaps before it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the sender until every result is back and the block is quiet
  task automatic settle_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_word_limit(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    word_limit = v;
  endtask

  // random byte generators
  function automatic logic [7:0] space_byte();
    int unsigned n;
    n = $urandom_range(9, 14);
    return (n == 14) ? CH_SPACE : 8'(n);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (white_space(b) || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH ||
           b == CH_HASH);
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte(input logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == q || (q == CH_DQUOTE && b == CH_BSLASH));
    return b;
  endfunction

  function automatic logic [7:0] escape_letter();
    case ($urandom_range(0, 4))
      0: return CH_B;
      1: return CH_F;
      2: return CH_N;
      3: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 4))
      0: return 8'd255;
      1: return 8'd0;
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_escape();
    send_byte(CH_BSLASH);
    case ($urandom_range(0, 3))
      0: send_byte(escape_letter());
      1: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(CH_ZERO, CH_SEVEN)));
      default: send_byte(8'($urandom_range(1, 255)));
    endcase
  endtask

  // a word built from bare bytes, quotes, escapes and hash bytes
  task automatic send_random_word();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 6))
        0, 1: send_byte(plain_byte());
        2: begin
          send_byte(CH_SQUOTE);
          repeat ($urandom_range(0, 3)) send_byte(quoted_byte(CH_SQUOTE));
          send_byte(CH_SQUOTE);
        end
        3: begin
          send_byte(CH_DQUOTE);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) == 0) send_escape();
            else send_byte(quoted_byte(CH_DQUOTE));
          end
          send_byte(CH_DQUOTE);
        end
        4, 5: send_escape();
        default: send_byte(CH_HASH);
      endcase
    end
  endtask

  // mostly well-formed lines, some noise and broken endings
  task automatic send_random_line();
    int unsigned words;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) send_byte(space_byte());
      words = $urandom_range(0, 6);
      for (int w = 0; w < words; w++) begin
        if (w != 0) repeat ($urandom_range(1, 2)) send_byte(space_byte());
        send_random_word();
      end
      case ($urandom_range(0, 7))
        0: begin
          send_byte(space_byte());
          send_byte(CH_HASH);
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)));
        end
        1: begin
          send_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
          repeat ($urandom_range(0, 2)) send_byte(plain_byte());
        end
        2: send_byte(space_byte());
        3: begin
          send_byte(CH_BSLASH);
          repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(CH_ZERO, CH_SEVEN)));
        end
        default: ;
      endcase
    end
    send_byte(CH_NUL);
  endtask

  // quotes, escapes, octal flush, pending octal at line end, comment
  task automatic test_directed_lines();
    send_text("a'x y'");
    send_byte(8'h0b);
    send_text("\"\\b\\377");
    send_byte(8'hff);
    send_text("\"\\7z");
    send_byte(CH_NUL);
    send_text("\\n\\12");
    send_byte(CH_NUL);
    send_byte(CH_HASH);
    send_byte(8'h01);
    send_byte(CH_NUL);
  endtask

  // word limit of zero and a small limit
  task automatic test_word_limits();
    settle_block();
    write_word_limit(8'd0);
    send_text("a b");
    send_byte(CH_NUL);
    settle_block();
    write_word_limit(8'd2);
    send_text("x y z");
    send_byte(CH_NUL);
  endtask

  // overflow on a long line of single-byte words
  task automatic test_long_line();
    settle_block();
    write_word_limit(8'd40);
    repeat (41) begin
      send_byte(plain_byte());
      send_byte(space_byte());
    end
    send_byte(CH_NUL);
  endtask

  task automatic test_random_lines(input int unsigned quota);
    int unsigned start;
    start = sent_items;
    settle_block();
    write_word_limit(pick_limit());
    while (sent_items - start < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        settle_block();
        write_word_limit(pick_limit());
      end
      send_random_line();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    stall_pct     = 55;
    test_directed_lines();
    test_word_limits();
    test_random_lines(130);

    send_idle_pct = 55;
    stall_pct     = 9;
    test_random_lines(130);

    send_idle_pct = 0;
    stall_pct     = 0;
    test_long_line();
    test_random_lines(130);

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
